[rtl/sfm_pkg.sv]
// sfm_pkg: shared types and constants for the substring search block
// no dependencies; used by every other file of the block

package sfm_pkg;

	// default sizes handed to the top level
	localparam int NEEDLE_MAX_DEF  = 8;
	localparam int OFFSET_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// fixed field widths
	localparam int TEXT_W     = 8;
	localparam int NEEDLE_W   = 64;
	localparam int LEN_W      = 4;
	localparam int OUT_OFF_W  = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;

	// character that ends a haystack
	localparam logic [TEXT_W-1:0] END_CHAR = 8'h00;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEEDLE_BYTES,
		REG_NEEDLE_LENGTH
	} cfg_reg_t;

	// classified item passed from front to back
	typedef struct packed {
		logic              is_end;
		logic [TEXT_W-1:0] text_byte;
	} sfm_item_t;

	// needle as seen by the back part
	typedef struct packed {
		logic [NEEDLE_W-1:0] bytes;
		logic [LEN_W-1:0]    eff_len;
	} sfm_needle_t;

endpackage

[rtl/sfm_ifs.sv]
// sfm_ifs: valid/ready channel interfaces for text input and search results
// depends on sfm_pkg

interface sfm_in_if
	import sfm_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [TEXT_W-1:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

interface sfm_out_if
	import sfm_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 match_found;
	logic [OUT_OFF_W-1:0] match_offset;
	logic                 length_overflow;

	modport source (output valid, output match_found, output match_offset,
		output length_overflow, input ready);
	modport sink (input valid, input match_found, input match_offset,
		input length_overflow, output ready);
endinterface

[rtl/sfm_front.sv]
// sfm_front: configuration registers, needle length trimming and item classification
// depends on sfm_pkg and sfm_ifs; feeds sfm_queue and sfm_back

module sfm_front
	import sfm_pkg::*;
#(
	parameter int NEEDLE_MAX = NEEDLE_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	sfm_in_if.sink                text_in,
	input  logic                  q_full,
	output logic                  q_push,
	output sfm_item_t             q_item,
	output sfm_needle_t           needle
);

	logic [NEEDLE_W-1:0] needle_bytes_q;
	logic [LEN_W-1:0]    needle_length_q;
	logic [LEN_W-1:0]    len_lim;
	logic [LEN_W-1:0]    eff_len;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_bytes_q  <= '0;
			needle_length_q <= '0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_NEEDLE_BYTES:  needle_bytes_q  <= wr_data[NEEDLE_W-1:0];
				REG_NEEDLE_LENGTH: needle_length_q <= wr_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// effective length: clip to window size, then cut at the first zero byte
	always_comb begin
		len_lim = needle_length_q;
		if (needle_length_q > LEN_W'(NEEDLE_MAX))
			len_lim = LEN_W'(NEEDLE_MAX);
		eff_len = len_lim;
		for (int i = NEEDLE_MAX - 1; i >= 0; i--) begin
			if (LEN_W'(i) < len_lim && needle_bytes_q[8*i +: 8] == END_CHAR)
				eff_len = LEN_W'(i);
		end
	end

	assign needle.bytes   = needle_bytes_q;
	assign needle.eff_len = eff_len;

	// accept while the queue has room, tag haystack terminators
	assign text_in.ready    = !q_full;
	assign q_push           = text_in.valid && !q_full;
	assign q_item.is_end    = (text_in.text_byte == END_CHAR);
	assign q_item.text_byte = text_in.text_byte;

endmodule

[rtl/sfm_queue.sv]
// sfm_queue: short first-in first-out queue of classified items
// depends on sfm_pkg; sits between sfm_front and sfm_back

module sfm_queue
	import sfm_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sfm_item_t push_item,
	input  logic      pop,
	output logic      full,
	output logic      head_valid,
	output sfm_item_t head_item,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	sfm_item_t         slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];
	assign count      = count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (!push && pop)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

endmodule

[rtl/sfm_back.sv]
// sfm_back: window compare, position counter, first-match capture and result register
// depends on sfm_pkg and sfm_ifs; drains sfm_queue

module sfm_back
	import sfm_pkg::*;
#(
	parameter int NEEDLE_MAX  = NEEDLE_MAX_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  sfm_needle_t needle,
	input  logic        head_valid,
	input  sfm_item_t   head_item,
	output logic        pop,
	sfm_out_if.source   result_out
);

	localparam logic [OFFSET_BITS-1:0] CMAX = '1;

	logic [TEXT_W-1:0]      win_q [NEEDLE_MAX];
	logic [TEXT_W-1:0]      win_nx [NEEDLE_MAX];
	logic [OFFSET_BITS-1:0] count_q;
	logic                   hit_q;
	logic [OFFSET_BITS-1:0] hit_off_q;
	logic                   ovf_q;

	logic                   res_valid_q;
	logic                   res_found_q;
	logic [OUT_OFF_W-1:0]   res_off_q;
	logic                   res_ovf_q;

	logic                   res_free;
	logic                   over_now;
	logic                   reach;
	logic                   cand;
	logic                   run_eq;
	logic                   hit_now;
	logic [OFFSET_BITS:0]   pos_next;
	logic [OFFSET_BITS-1:0] off_calc;
	logic [31:0]            off_ext;

	// take a plain character always, a terminator only when the result slot frees
	assign res_free = !res_valid_q || result_out.ready;
	assign pop      = head_valid && (!head_item.is_end || res_free);
	assign over_now = (count_q == CMAX);

	// shifted window with the new character in front
	always_comb begin
		win_nx[0] = head_item.text_byte;
		for (int k = 1; k < NEEDLE_MAX; k++)
			win_nx[k] = win_q[k-1];
	end

	// compare every candidate needle length, keep the one in use
	always_comb begin
		cand = 1'b0;
		for (int l = 1; l <= NEEDLE_MAX; l++) begin
			run_eq = 1'b1;
			for (int i = 0; i < l; i++) begin
				if (win_nx[l-1-i] != needle.bytes[8*i +: 8])
					run_eq = 1'b0;
			end
			if (needle.eff_len == LEN_W'(l))
				cand = run_eq;
		end
	end

	// enough characters seen, and start offset of a match ending here
	always_comb begin
		pos_next = {1'b0, count_q} + 1'b1;
		reach    = (pos_next >= (OFFSET_BITS+1)'(needle.eff_len));
		hit_now  = !hit_q && (needle.eff_len != '0) && reach && cand;
		off_calc = over_now ? CMAX
			: OFFSET_BITS'(pos_next - (OFFSET_BITS+1)'(needle.eff_len));
		off_ext  = 32'(hit_off_q);
	end

	// per-haystack state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NEEDLE_MAX; k++)
				win_q[k] <= '0;
			count_q   <= '0;
			hit_q     <= 1'b0;
			hit_off_q <= '0;
			ovf_q     <= 1'b0;
		end else if (pop) begin
			if (head_item.is_end) begin
				for (int k = 0; k < NEEDLE_MAX; k++)
					win_q[k] <= '0;
				count_q   <= '0;
				hit_q     <= 1'b0;
				hit_off_q <= '0;
				ovf_q     <= 1'b0;
			end else begin
				for (int k = 0; k < NEEDLE_MAX; k++)
					win_q[k] <= win_nx[k];
				if (!over_now)
					count_q <= count_q + 1'b1;
				if (over_now)
					ovf_q <= 1'b1;
				if (hit_now) begin
					hit_q     <= 1'b1;
					hit_off_q <= off_calc;
				end
			end
		end
	end

	// result slot valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && head_item.is_end) begin
			res_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && head_item.is_end) begin
			if (needle.eff_len == '0) begin
				res_found_q <= 1'b1;
				res_off_q   <= '0;
			end else begin
				res_found_q <= hit_q;
				res_off_q   <= hit_q ? off_ext[OUT_OFF_W-1:0] : '0;
			end
			res_ovf_q <= ovf_q;
		end
	end

	assign result_out.valid           = res_valid_q;
	assign result_out.match_found     = res_found_q;
	assign result_out.match_offset    = res_off_q;
	assign result_out.length_overflow = res_ovf_q;

endmodule

[rtl/substring_first_match.sv]
// substring_first_match: one haystack byte per item, one result per zero terminator.
// Throughput: one item per cycle unless the queue or result slot stalls, set by the
// single window compare in the back part. A result is registered when its terminator
// is taken; a stalled result slot holds terminators in the four-entry queue.
// Reset: arst_n clears the needle, the queue, the window and all match state at once.

module substring_first_match
	import sfm_pkg::*;
#(
	parameter int NEEDLE_MAX  = NEEDLE_MAX_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	sfm_in_if.sink                text_in,
	sfm_out_if.source             result_out
);

	logic                             q_push;
	logic                             q_pop;
	logic                             q_full;
	logic                             q_valid;
	sfm_item_t                        q_in;
	sfm_item_t                        q_head;
	sfm_needle_t                      needle;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	// intake and configuration
	sfm_front #(
		.NEEDLE_MAX (NEEDLE_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.text_in  (text_in),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_in),
		.needle   (needle)
	);

	// decoupling queue
	sfm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_in),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head_item  (q_head),
		.count      (q_count)
	);

	// search and result
	sfm_back #(
		.NEEDLE_MAX  (NEEDLE_MAX),
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.needle     (needle),
		.head_valid (q_valid),
		.head_item  (q_head),
		.pop        (q_pop),
		.result_out (result_out)
	);

`ifndef SYNTHESIS
	// queue level follows a lone push
	a_queue_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> (q_count == $past(q_count) + 1'b1))
		else $error("queue level did not follow a push");

	// a taken result leaves the slot empty unless a terminator refilled it
	a_result_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && result_out.ready && !(q_pop && q_head.is_end))
		|=> !result_out.valid)
		else $error("result slot not released");

	// no offset without a match
	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> (result_out.match_found || result_out.match_offset == '0))
		else $error("offset reported without a match");
`endif

endmodule
